[sv/tivh_pkg.sv]
// shared constants, types and helpers for the track identity vote histogram
package tivh_pkg;

	localparam int MAX_TRACKS = 16;
	localparam int FACE_BINS = 30;
	localparam int GUESSES = 3;
	localparam int SLOT_W = $clog2(MAX_TRACKS);
	localparam int BIN_W = $clog2(FACE_BINS);
	localparam int PNUM_W = 5;
	localparam int COUNT_W = 16;
	localparam int TAG_W = 64;
	localparam int ID_W = 5;
	localparam int CONF_W = 10;
	localparam int ADD_W = 4;
	localparam int VOTES = MAX_TRACKS * FACE_BINS;
	localparam int VADDR_W = $clog2(VOTES);
	localparam logic [COUNT_W-1:0] VOTE_MAX = '1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// sequencer state codes
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_LOOK = 3'd2;
	localparam logic [2:0] ST_RD = 3'd3;
	localparam logic [2:0] ST_WR = 3'd4;
	localparam logic [2:0] ST_SCAN = 3'd5;
	localparam logic [2:0] ST_LAST = 3'd6;

	// tag lookup result from the match lanes
	typedef struct packed {
		logic hit;
		logic [SLOT_W-1:0] slot;
	} match_t;

	// confidence divided by 100, small table over 10 bits
	function automatic logic [ADD_W-1:0] conf_votes(input logic [CONF_W-1:0] c);
		logic [ADD_W-1:0] q;
		q = '0;
		if (c >= 10'd100) q = 4'd1;
		if (c >= 10'd200) q = 4'd2;
		if (c >= 10'd300) q = 4'd3;
		if (c >= 10'd400) q = 4'd4;
		if (c >= 10'd500) q = 4'd5;
		if (c >= 10'd600) q = 4'd6;
		if (c >= 10'd700) q = 4'd7;
		if (c >= 10'd800) q = 4'd8;
		if (c >= 10'd900) q = 4'd9;
		if (c >= 10'd1000) q = 4'd10;
		return q;
	endfunction

endpackage

[sv/track_identity_vote_histogram.sv]
// track identity vote histogram top level
// sequence: tag lookup, a vote ram read and, for guesses inside the bins, a write per guess, then a 30-bin argmax walk
// one request at a time: start is taken only while busy is low; results cannot stall
// a zero tracking id is taken with no result; a full table answers with status full
// after reset the vote ram is cleared, one entry a cycle (all 480 entries, busy high)
module track_identity_vote_histogram import tivh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [TAG_W-1:0]   body_tag,
	input  logic [ID_W-1:0]    face_id_a,
	input  logic [CONF_W-1:0]  face_conf_a,
	input  logic [ID_W-1:0]    face_id_b,
	input  logic [CONF_W-1:0]  face_conf_b,
	input  logic [ID_W-1:0]    face_id_c,
	input  logic [CONF_W-1:0]  face_conf_c,
	output logic               done,
	output logic [PNUM_W-1:0]  person_number,
	output logic [BIN_W-1:0]   best_face_id,
	output logic [COUNT_W-1:0] best_score,
	output logic               status
);

	logic [2:0] state_q;
	logic [TAG_W-1:0] tag_q;
	logic [ID_W-1:0] gid_q [GUESSES];
	logic [ADD_W-1:0] gadd_q [GUESSES];
	logic [$clog2(GUESSES+1)-1:0] g_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W:0] next_q;
	logic [VADDR_W-1:0] clr_q;
	logic [BIN_W-1:0] bin_q;
	logic [BIN_W-1:0] best_q;
	logic [COUNT_W-1:0] score_q;
	match_t match;
	logic tag_wr;
	logic ram_we;
	logic [VADDR_W-1:0] ram_addr;
	logic [COUNT_W-1:0] ram_wdata, ram_rdata;
	logic [ID_W-1:0] cur_id;
	logic [COUNT_W:0] sum;
	logic [VADDR_W-1:0] base;

	assign busy = (state_q != ST_IDLE);
	assign tag_wr = (state_q == ST_LOOK) && !match.hit && (next_q < (SLOT_W+1)'(MAX_TRACKS));
	assign base = VADDR_W'(slot_q) * VADDR_W'(FACE_BINS);
	assign cur_id = gid_q[g_q[$clog2(GUESSES)-1:0]];
	assign sum = {1'b0, ram_rdata} + (COUNT_W+1)'(gadd_q[g_q[$clog2(GUESSES)-1:0]]);

	tivh_match u_match (
		.clk(clk), .arst_n(arst_n), .wr(tag_wr), .wr_slot(next_q[SLOT_W-1:0]),
		.tag(tag_q), .match(match)
	);

	tivh_ram #(.WIDTH(COUNT_W), .DEPTH(VOTES)) u_votes (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// vote ram port control
	always_comb begin
		ram_we = 1'b0;
		ram_wdata = '0;
		ram_addr = base + VADDR_W'(cur_id);
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
			end
			ST_WR: begin
				ram_we = 1'b1;
				ram_wdata = sum[COUNT_W] ? VOTE_MAX : sum[COUNT_W-1:0];
			end
			ST_SCAN, ST_LAST: ram_addr = base + VADDR_W'(bin_q);
			default: ;
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			tag_q <= body_tag;
			gid_q[0] <= face_id_a;
			gadd_q[0] <= conf_votes(face_conf_a);
			gid_q[1] <= face_id_b;
			gadd_q[1] <= conf_votes(face_conf_b);
			gid_q[2] <= face_id_c;
			gadd_q[2] <= conf_votes(face_conf_c);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			next_q <= '0;
			g_q <= '0;
			slot_q <= '0;
			bin_q <= '0;
			best_q <= '0;
			score_q <= '0;
			done <= 1'b0;
			person_number <= '0;
			best_face_id <= '0;
			best_score <= '0;
			status <= STATUS_OK;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VADDR_W'(VOTES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start && body_tag != '0) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					g_q <= '0;
					if (match.hit) begin
						slot_q <= match.slot;
						state_q <= ST_RD;
					end else if (tag_wr) begin
						slot_q <= next_q[SLOT_W-1:0];
						next_q <= next_q + 1'b1;
						state_q <= ST_RD;
					end else begin
						done <= 1'b1;
						person_number <= '0;
						best_face_id <= '0;
						best_score <= '0;
						status <= STATUS_FULL;
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					// skip guesses outside the bins
					if (g_q == GUESSES[$bits(g_q)-1:0]) begin
						bin_q <= '0;
						state_q <= ST_SCAN;
					end else if (cur_id >= ID_W'(FACE_BINS)) begin
						g_q <= g_q + 1'b1;
					end else begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					g_q <= g_q + 1'b1;
					state_q <= ST_RD;
				end
				ST_SCAN: begin
					// read of bin 0 issued; data arrives next cycle
					bin_q <= bin_q + 1'b1;
					score_q <= '0;
					best_q <= '0;
					state_q <= ST_LAST;
				end
				ST_LAST: begin
					// ram_rdata holds bin bin_q-1
					if (bin_q == BIN_W'(1) || ram_rdata > score_q) begin
						score_q <= ram_rdata;
						best_q <= bin_q - 1'b1;
					end
					if (bin_q == BIN_W'(FACE_BINS)) begin
						done <= 1'b1;
						status <= STATUS_OK;
						person_number <= PNUM_W'(slot_q) + 1'b1;
						if (ram_rdata > score_q) begin
							best_face_id <= bin_q - 1'b1;
							best_score <= ram_rdata;
						end else begin
							best_face_id <= best_q;
							best_score <= score_q;
						end
						state_q <= ST_IDLE;
					end else begin
						bin_q <= bin_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/tivh_ram.sv]
// generic single-port ram with registered read
module tivh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 480
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// registered read returns the old entry on a write to the same address
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

[sv/tivh_match.sv]
// parallel tag compare lanes with a priority merge
module tivh_match import tivh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [SLOT_W-1:0] wr_slot,
	input  logic [TAG_W-1:0] tag,
	output match_t           match
);

	logic [TAG_W-1:0] tags_q [MAX_TRACKS];
	logic [MAX_TRACKS-1:0] valid_q;
	logic [MAX_TRACKS-1:0] hit;

	// tag store
	always_ff @(posedge clk) begin
		if (wr) tags_q[wr_slot] <= tag;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr) begin
			valid_q[wr_slot] <= 1'b1;
		end
	end

	// one compare lane per slot
	always_comb begin
		for (int k = 0; k < MAX_TRACKS; k++) hit[k] = valid_q[k] && (tags_q[k] == tag);
	end

	// merge: lowest matching slot
	always_comb begin
		match = '0;
		for (int k = MAX_TRACKS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				match.hit = 1'b1;
				match.slot = SLOT_W'(k);
			end
		end
	end

endmodule

[verif/tb_top.sv]
// testbench for the track identity vote histogram: directed, random, heavy-bin and full-table tests
module tb_top;
	import tivh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [PNUM_W-1:0]  person;
		logic [BIN_W-1:0]   best;
		logic [COUNT_W-1:0] score;
		logic               stat;
	} vote_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [TAG_W-1:0]   body_tag = '0;
	logic [ID_W-1:0]    face_id_a = '0;
	logic [CONF_W-1:0]  face_conf_a = '0;
	logic [ID_W-1:0]    face_id_b = '0;
	logic [CONF_W-1:0]  face_conf_b = '0;
	logic [ID_W-1:0]    face_id_c = '0;
	logic [CONF_W-1:0]  face_conf_c = '0;
	logic               done;
	logic [PNUM_W-1:0]  person_number;
	logic [BIN_W-1:0]   best_face_id;
	logic [COUNT_W-1:0] best_score;
	logic               status;

	// predictor state
	logic [TAG_W-1:0]   tag_table [MAX_TRACKS];
	logic               tag_used [MAX_TRACKS];
	int                 persons_in_use;
	logic [COUNT_W-1:0] votes [MAX_TRACKS][FACE_BINS];

	vote_result_t expected_votes [$];
	int  errors = 0;
	int  quiet_cycles = 0;
	bit  gaps_on = 1'b1;

	track_identity_vote_histogram dut (.*);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// clear the predictor to the reset state
	task automatic clear_predictor();
		persons_in_use = 0;
		foreach (tag_used[k]) tag_used[k] = 1'b0;
		foreach (votes[p, b]) votes[p][b] = '0;
	endtask

	// predict the result of one request, return 1 if one is produced
	function automatic bit predict_vote(input logic [TAG_W-1:0] tag,
			input logic [ID_W-1:0] ids [GUESSES], input logic [CONF_W-1:0] confs [GUESSES],
			output vote_result_t r);
		int slot;
		logic [COUNT_W:0] sum;
		slot = -1;
		r = '{default: '0};
		if (tag == '0) return 1'b0;
		for (int k = 0; k < MAX_TRACKS; k++)
			if (slot < 0 && tag_used[k] && tag_table[k] == tag) slot = k;
		if (slot < 0) begin
			if (persons_in_use >= MAX_TRACKS) begin
				r.stat = STATUS_FULL;
				return 1'b1;
			end
			slot = persons_in_use;
			tag_table[slot] = tag;
			tag_used[slot] = 1'b1;
			persons_in_use++;
		end
		for (int g = 0; g < GUESSES; g++) begin
			if (ids[g] < FACE_BINS) begin
				sum = {1'b0, votes[slot][ids[g]]} + confs[g] / 100;
				votes[slot][ids[g]] = sum > VOTE_MAX ? VOTE_MAX : sum[COUNT_W-1:0];
			end
		end
		r.best = '0;
		r.score = votes[slot][0];
		for (int b = 1; b < FACE_BINS; b++)
			if (votes[slot][b] > r.score) begin
				r.best = b[BIN_W-1:0];
				r.score = votes[slot][b];
			end
		r.person = PNUM_W'(slot + 1);
		r.stat = STATUS_OK;
		return 1'b1;
	endfunction

	// random gap before a request
	task automatic maybe_gap();
		int n;
		if (gaps_on && $urandom_range(0, 99) < 18) begin
			n = $urandom_range(1, 4);
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// send one request and record its expected result
	task automatic send_body(input logic [TAG_W-1:0] tag,
			input logic [ID_W-1:0] ia, input logic [CONF_W-1:0] ca,
			input logic [ID_W-1:0] ib, input logic [CONF_W-1:0] cb,
			input logic [ID_W-1:0] ic, input logic [CONF_W-1:0] cc);
		logic [ID_W-1:0] ids [GUESSES];
		logic [CONF_W-1:0] confs [GUESSES];
		vote_result_t r;
		maybe_gap();
		@(negedge clk);
		start = 1'b1;
		body_tag = tag;
		face_id_a = ia; face_conf_a = ca;
		face_id_b = ib; face_conf_b = cb;
		face_id_c = ic; face_conf_c = cc;
		@(posedge clk);
		while (busy) @(posedge clk);
		ids = '{ia, ib, ic};
		confs = '{ca, cb, cc};
		if (predict_vote(tag, ids, confs, r)) expected_votes.push_back(r);
	endtask

	// hold requests until every expected result has come back
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (expected_votes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// pick a tag: mostly known persons, some new, some untracked
	function automatic logic [TAG_W-1:0] pick_tag();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) return '0;
		if (sel < 16 || persons_in_use == 0) return {$urandom, $urandom};
		return tag_table[$urandom_range(0, persons_in_use - 1)];
	endfunction

	// random guess id, mostly in a few bins so winners change
	function automatic logic [ID_W-1:0] pick_id();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50) return ID_W'($urandom_range(0, 4));
		return ID_W'($urandom_range(0, 31));
	endfunction

	task automatic test_directed();
		send_body('0, 5'd1, 10'd1000, 5'd2, 10'd1000, 5'd3, 10'd1000);
		send_body('1, 5'd0, 10'd0, 5'd0, 10'd99, 5'd0, 10'd0);
		send_body('1, 5'd29, 10'd1023, 5'd29, 10'd1000, 5'd29, 10'd100);
		send_body(64'h5555_5555_5555_5555, 5'd30, 10'd1000, 5'd31, 10'd1023, 5'd31, 10'd999);
		send_body(64'hAAAA_AAAA_AAAA_AAAA, 5'd7, 10'd500, 5'd8, 10'd500, 5'd9, 10'd199);
		send_body(64'hAAAA_AAAA_AAAA_AAAA, 5'd8, 10'd0, 5'd7, 10'd0, 5'd9, 10'd0);
		send_body(64'h5555_5555_5555_5555, 5'd0, 10'd1023, 5'd0, 10'd1023, 5'd0, 10'd1023);
		send_body(64'h1, 5'd15, 10'd512, 5'd16, 10'd256, 5'd31, 10'd1000);
		send_body(64'h8000_0000_0000_0000, 5'd10, 10'd300, 5'd20, 10'd300, 5'd30, 10'd300);
		send_body('1, 5'd1, 10'd1000, 5'd2, 10'd1000, 5'd0, 10'd0);
		drain();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			gaps_on = !(i >= n / 3 && i < n / 2);
			send_body(pick_tag(), pick_id(), CONF_W'($urandom_range(0, 1023)),
				pick_id(), CONF_W'($urandom_range(0, 1023)),
				pick_id(), CONF_W'($urandom_range(0, 1023)));
		end
		gaps_on = 1'b1;
		drain();
	endtask

	// pile votes into one bin of one person, back to back
	task automatic test_heavy_bin();
		logic [TAG_W-1:0] tag;
		tag = persons_in_use > 0 ? tag_table[0] : 64'hC0FFEE;
		gaps_on = 1'b0;
		for (int i = 0; i < 100; i++)
			send_body(tag, 5'd12, 10'd1000, 5'd12, 10'd1023, 5'd12, 10'd1000);
		gaps_on = 1'b1;
		drain();
	endtask

	// fill the tag table, then unknown tags report full, then random requests
	task automatic test_table_full();
		while (persons_in_use < MAX_TRACKS)
			send_body({$urandom, $urandom} | 64'h1, pick_id(), 10'd600, pick_id(), 10'd400,
				pick_id(), 10'd1000);
		for (int i = 0; i < 20; i++)
			send_body({$urandom, $urandom} | 64'h2, 5'd3, 10'd900, 5'd4, 10'd900, 5'd5, 10'd900);
		test_random(60);
	endtask

	// result checker
	always @(posedge clk) begin
		vote_result_t e;
		if (arst_n && done) begin
			if (expected_votes.size() == 0) begin
				$display("%0t: unexpected result person %0d best %0d score %0d status %0d",
					$time, person_number, best_face_id, best_score, status);
				errors++;
			end else begin
				e = expected_votes.pop_front();
				if (person_number !== e.person || best_face_id !== e.best ||
						best_score !== e.score || status !== e.stat) begin
					$display("%0t: mismatch expected person %0d best %0d score %0d status %0d",
						$time, e.person, e.best, e.score, e.stat);
					$display("%0t:          actual person %0d best %0d score %0d status %0d",
						$time, person_number, best_face_id, best_score, status);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no progress
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// test sequence
	initial begin
		clear_predictor();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(300);
		test_heavy_bin();
		test_table_full();
		if (expected_votes.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_votes.size());
			errors++;
		end
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
